// ===== hdl/minv_pkg.sv =====
// Package for the 3x3 matrix inverse: widths, cofactor index tables and the
// types of the divider pipeline stages.
// Depends on nothing; used by matrix_inverse_3x3.
package minv_pkg;

   localparam int ENTRY_WIDTH = 16;
   localparam int FRAC_BITS   = 12;
   localparam int OUT_FRAC    = 16;
   localparam int OUT_WIDTH   = 32;
   localparam int DET_WIDTH   = 50;

   localparam int PROD_WIDTH  = 2 * ENTRY_WIDTH;
   localparam int ADJ_WIDTH   = PROD_WIDTH + 1;
   localparam int DPROD_WIDTH = ENTRY_WIDTH + ADJ_WIDTH;
   localparam int MAG_WIDTH   = ADJ_WIDTH - 1;
   localparam int ND_WIDTH    = DET_WIDTH - 2;
   localparam int SHIFT       = FRAC_BITS + OUT_FRAC;
   localparam int Q_WIDTH     = OUT_WIDTH + 1;
   localparam int HEAD_SHIFT  = Q_WIDTH - SHIFT;
   localparam int N_STEPS     = Q_WIDTH;
   localparam int N_ENTRIES   = 9;

   localparam logic [Q_WIDTH-1:0] POS_LIMIT = Q_WIDTH'(33'h0_7FFF_FFFF);
   localparam logic [Q_WIDTH-1:0] NEG_LIMIT = Q_WIDTH'(33'h0_8000_0000);

   // Cofactor k is m[PA]*m[PB] - m[NA]*m[NB] (already transposed).
   localparam logic [3:0] COF_PA [N_ENTRIES] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0,
                                                4'd2, 4'd3, 4'd1, 4'd0};
   localparam logic [3:0] COF_PB [N_ENTRIES] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8,
                                                4'd3, 4'd7, 4'd6, 4'd4};
   localparam logic [3:0] COF_NA [N_ENTRIES] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2,
                                                4'd0, 4'd4, 4'd0, 4'd1};
   localparam logic [3:0] COF_NB [N_ENTRIES] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6,
                                                4'd5, 4'd6, 4'd7, 4'd3};

   typedef struct packed {
      logic [ND_WIDTH-1:0]  rem;
      logic [Q_WIDTH-1:0]   quot;
      logic [MAG_WIDTH-1:0] num;
      logic                 neg;
      logic                 sat;
   } lane_type;

   typedef struct packed {
      logic [ND_WIDTH-1:0]        den;
      logic signed [DET_WIDTH-1:0] det;
      logic                       singular;
      lane_type [N_ENTRIES-1:0]   lane;
   } div_stage_type;

endpackage

// ===== hdl/matrix_inverse_3x3.sv =====
// 3x3 matrix inverse by the adjugate, fully pipelined.
// Depends on minv_pkg for widths, cofactor tables and stage types.
//
// Usage: a 3x3 matrix of signed Q4.12 entries arrives as one word on the
// req_ channel (req_valid/req_ready); the inverse in signed Q16.16, the
// exact determinant scaled by 2^36 and a singular flag leave as one word on
// the rsp_ channel (rsp_valid/rsp_ready). Entries are truncated toward zero
// and saturated; a singular matrix gives all-zero entries.
// Between acceptance and rsp_valid, two stages form the cofactors, two the
// determinant, one takes magnitudes, 33 stages of restoring long division
// produce one quotient bit each for all nine entries in parallel, and one
// stage saturates into the output word.
// Throughput is one matrix per cycle. The whole pipeline advances together;
// when the receiver holds rsp_ready low with a word waiting, every stage
// holds and req_ready falls, so nothing is lost or repeated.
// Synchronous reset clears every valid bit; data registers are not reset.
module matrix_inverse_3x3 import minv_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [ENTRY_WIDTH-1:0] req_a00,
   input  logic signed [ENTRY_WIDTH-1:0] req_a01,
   input  logic signed [ENTRY_WIDTH-1:0] req_a02,
   input  logic signed [ENTRY_WIDTH-1:0] req_a10,
   input  logic signed [ENTRY_WIDTH-1:0] req_a11,
   input  logic signed [ENTRY_WIDTH-1:0] req_a12,
   input  logic signed [ENTRY_WIDTH-1:0] req_a20,
   input  logic signed [ENTRY_WIDTH-1:0] req_a21,
   input  logic signed [ENTRY_WIDTH-1:0] req_a22,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [OUT_WIDTH-1:0] rsp_b00,
   output logic signed [OUT_WIDTH-1:0] rsp_b01,
   output logic signed [OUT_WIDTH-1:0] rsp_b02,
   output logic signed [OUT_WIDTH-1:0] rsp_b10,
   output logic signed [OUT_WIDTH-1:0] rsp_b11,
   output logic signed [OUT_WIDTH-1:0] rsp_b12,
   output logic signed [OUT_WIDTH-1:0] rsp_b20,
   output logic signed [OUT_WIDTH-1:0] rsp_b21,
   output logic signed [OUT_WIDTH-1:0] rsp_b22,
   output logic signed [DET_WIDTH-1:0] rsp_determinant,
   output logic                        rsp_singular
);

   localparam int N_FRONT = 5;
   localparam int N_VALID = N_FRONT + N_STEPS + 1;

   logic                          advance;
   logic [N_VALID-1:0]            valid_ff;
   logic [N_VALID-1:0]            valid_in;

   logic signed [ENTRY_WIDTH-1:0] m [N_ENTRIES];

   logic signed [PROD_WIDTH-1:0]  pp_ff [N_ENTRIES];
   logic signed [PROD_WIDTH-1:0]  np_ff [N_ENTRIES];
   logic signed [ENTRY_WIDTH-1:0] row1_ff [3];
   logic signed [ADJ_WIDTH-1:0]   adj2_ff [N_ENTRIES];
   logic signed [ENTRY_WIDTH-1:0] row2_ff [3];
   logic signed [ADJ_WIDTH-1:0]   adj3_ff [N_ENTRIES];
   logic signed [DPROD_WIDTH-1:0] dp3_ff [3];
   logic signed [ADJ_WIDTH-1:0]   adj4_ff [N_ENTRIES];
   logic signed [DET_WIDTH-1:0]   det4_ff;

   div_stage_type                 div_ff [N_STEPS+1];
   div_stage_type                 div_in [N_STEPS+1];

   logic signed [OUT_WIDTH-1:0]   b_ff [N_ENTRIES];
   logic signed [OUT_WIDTH-1:0]   b_in [N_ENTRIES];
   logic signed [DET_WIDTH-1:0]   det_out_ff;
   logic                          sing_out_ff;

   assign advance   = !valid_ff[N_VALID-1] || rsp_ready;
   assign req_ready = advance;

   assign m[0] = req_a00;
   assign m[1] = req_a01;
   assign m[2] = req_a02;
   assign m[3] = req_a10;
   assign m[4] = req_a11;
   assign m[5] = req_a12;
   assign m[6] = req_a20;
   assign m[7] = req_a21;
   assign m[8] = req_a22;

   assign valid_in = {valid_ff[N_VALID-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Cofactor products, cofactors, determinant terms and determinant.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < N_ENTRIES; k++) begin
            pp_ff[k]   <= PROD_WIDTH'(m[COF_PA[k]] * m[COF_PB[k]]);
            np_ff[k]   <= PROD_WIDTH'(m[COF_NA[k]] * m[COF_NB[k]]);
            adj2_ff[k] <= ADJ_WIDTH'(pp_ff[k]) - ADJ_WIDTH'(np_ff[k]);
            adj3_ff[k] <= adj2_ff[k];
            adj4_ff[k] <= adj3_ff[k];
         end
         for (int c = 0; c < 3; c++) begin
            row1_ff[c] <= m[c];
            row2_ff[c] <= row1_ff[c];
         end
         dp3_ff[0] <= DPROD_WIDTH'(row2_ff[0] * adj2_ff[0]);
         dp3_ff[1] <= DPROD_WIDTH'(row2_ff[1] * adj2_ff[3]);
         dp3_ff[2] <= DPROD_WIDTH'(row2_ff[2] * adj2_ff[6]);
         det4_ff   <= DET_WIDTH'(dp3_ff[0]) + DET_WIDTH'(dp3_ff[1])
                    + DET_WIDTH'(dp3_ff[2]);
      end
   end

   // Magnitudes, signs and the overflow test ahead of the divider, then one
   // quotient bit per stage for all nine entries.
   always_comb begin
      logic [ND_WIDTH-1:0]  den;
      logic [MAG_WIDTH-1:0] num;
      logic signed [ADJ_WIDTH-1:0] neg_adj;
      logic signed [DET_WIDTH-1:0] neg_det;
      logic [ND_WIDTH:0]    part;
      logic [ND_WIDTH:0]    trial;
      logic                 nbit;
      int                   bit_pos;
      neg_det = -det4_ff;
      den     = det4_ff[DET_WIDTH-1] ? neg_det[ND_WIDTH-1:0] : det4_ff[ND_WIDTH-1:0];
      div_in[0].den      = den;
      div_in[0].det      = det4_ff;
      div_in[0].singular = (det4_ff == '0);
      for (int k = 0; k < N_ENTRIES; k++) begin
         neg_adj = -adj4_ff[k];
         num = adj4_ff[k][ADJ_WIDTH-1] ? neg_adj[MAG_WIDTH-1:0]
                                       : adj4_ff[k][MAG_WIDTH-1:0];
         div_in[0].lane[k].num  = num;
         div_in[0].lane[k].neg  = adj4_ff[k][ADJ_WIDTH-1] ^ det4_ff[DET_WIDTH-1];
         div_in[0].lane[k].sat  = (ND_WIDTH + HEAD_SHIFT)'(num)
                                  >= {den, HEAD_SHIFT'(0)};
         div_in[0].lane[k].rem  = ND_WIDTH'(num >> HEAD_SHIFT);
         div_in[0].lane[k].quot = '0;
      end
      for (int s = 0; s < N_STEPS; s++) begin
         bit_pos = N_STEPS - 1 - s;
         div_in[s+1] = div_ff[s];
         for (int k = 0; k < N_ENTRIES; k++) begin
            if (bit_pos >= SHIFT) begin
               nbit = div_ff[s].lane[k].num[(bit_pos >= SHIFT) ? bit_pos - SHIFT : 0];
            end else begin
               nbit = 1'b0;
            end
            part  = {div_ff[s].lane[k].rem, nbit};
            trial = part - {1'b0, div_ff[s].den};
            if (!trial[ND_WIDTH]) begin
               div_in[s+1].lane[k].rem           = trial[ND_WIDTH-1:0];
               div_in[s+1].lane[k].quot[bit_pos] = 1'b1;
            end else begin
               div_in[s+1].lane[k].rem           = part[ND_WIDTH-1:0];
               div_in[s+1].lane[k].quot[bit_pos] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s <= N_STEPS; s++) begin
            div_ff[s] <= div_in[s];
         end
      end
   end

   // Sign and saturation into the output word.
   always_comb begin
      lane_type            ln;
      logic [Q_WIDTH-1:0]  neg_q;
      for (int k = 0; k < N_ENTRIES; k++) begin
         ln    = div_ff[N_STEPS].lane[k];
         neg_q = -ln.quot;
         if (div_ff[N_STEPS].singular) begin
            b_in[k] = '0;
         end else if (ln.neg) begin
            b_in[k] = (ln.sat || ln.quot > NEG_LIMIT) ? NEG_LIMIT[OUT_WIDTH-1:0]
                                                      : neg_q[OUT_WIDTH-1:0];
         end else begin
            b_in[k] = (ln.sat || ln.quot > POS_LIMIT) ? POS_LIMIT[OUT_WIDTH-1:0]
                                                      : ln.quot[OUT_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < N_ENTRIES; k++) begin
            b_ff[k] <= b_in[k];
         end
         det_out_ff  <= div_ff[N_STEPS].det;
         sing_out_ff <= div_ff[N_STEPS].singular;
      end
   end

   assign rsp_valid       = valid_ff[N_VALID-1];
   assign rsp_b00         = b_ff[0];
   assign rsp_b01         = b_ff[1];
   assign rsp_b02         = b_ff[2];
   assign rsp_b10         = b_ff[3];
   assign rsp_b11         = b_ff[4];
   assign rsp_b12         = b_ff[5];
   assign rsp_b20         = b_ff[6];
   assign rsp_b21         = b_ff[7];
   assign rsp_b22         = b_ff[8];
   assign rsp_determinant = det_out_ff;
   assign rsp_singular    = sing_out_ff;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for matrix_inverse_3x3: drives random and directed
// matrices, predicts inverse, determinant and singular flag, and checks them.
// Depends on minv_pkg and matrix_inverse_3x3.
`timescale 1ns / 100ps

module testbench;
   import minv_pkg::*;

   typedef logic signed [ENTRY_WIDTH-1:0] entry_type;

   typedef struct {
      logic signed [OUT_WIDTH-1:0] b [N_ENTRIES];
      logic signed [DET_WIDTH-1:0] det;
      logic                        singular;
   } inverse_word_type;

   class inverse_scoreboard_type;
      inverse_word_type pending [$];
      int               mismatches = 0;

      function logic signed [OUT_WIDTH-1:0] divide_saturate(longint adj, longint det);
         logic [127:0] num, den, quot;
         bit           neg;
         neg  = (adj < 0) != (det < 0);
         num  = (adj < 0) ? -adj : adj;
         den  = (det < 0) ? -det : det;
         quot = (num << SHIFT) / den;
         if (neg) begin
            if (quot > 128'h8000_0000) quot = 128'h8000_0000;
            return -quot[OUT_WIDTH-1:0];
         end
         if (quot > 128'h7FFF_FFFF) quot = 128'h7FFF_FFFF;
         return quot[OUT_WIDTH-1:0];
      endfunction

      function void note_matrix(entry_type m [N_ENTRIES]);
         longint           e [N_ENTRIES];
         longint           adj [N_ENTRIES];
         longint           det;
         inverse_word_type w;
         foreach (e[k]) e[k] = m[k];
         det = e[0]*e[4]*e[8] + e[1]*e[5]*e[6] + e[2]*e[3]*e[7]
             - e[2]*e[4]*e[6] - e[1]*e[3]*e[8] - e[0]*e[5]*e[7];
         adj[0] = e[4]*e[8] - e[5]*e[7];
         adj[1] = e[2]*e[7] - e[1]*e[8];
         adj[2] = e[1]*e[5] - e[2]*e[4];
         adj[3] = e[5]*e[6] - e[3]*e[8];
         adj[4] = e[0]*e[8] - e[2]*e[6];
         adj[5] = e[2]*e[3] - e[0]*e[5];
         adj[6] = e[3]*e[7] - e[4]*e[6];
         adj[7] = e[1]*e[6] - e[0]*e[7];
         adj[8] = e[0]*e[4] - e[1]*e[3];
         foreach (adj[k]) w.b[k] = (det == 0) ? '0 : divide_saturate(adj[k], det);
         w.det      = det[DET_WIDTH-1:0];
         w.singular = (det == 0);
         pending = {pending, w};
      endfunction

      function void check_word(inverse_word_type got);
         inverse_word_type want;
         if (pending.size() == 0) begin
            $error("unexpected result word");
            mismatches++;
            return;
         end
         want = pending.pop_front();
         foreach (want.b[k])
            if (got.b[k] !== want.b[k]) begin
               $error("b%0d%0d: expected %0d, got %0d", k / 3, k % 3, want.b[k], got.b[k]);
               mismatches++;
            end
         if (got.det !== want.det) begin
            $error("determinant: expected %0d, got %0d", want.det, got.det);
            mismatches++;
         end
         if (got.singular !== want.singular) begin
            $error("singular: expected %0d, got %0d", want.singular, got.singular);
            mismatches++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   entry_type req_a [N_ENTRIES];
   logic signed [OUT_WIDTH-1:0] rsp_b [N_ENTRIES];
   logic signed [DET_WIDTH-1:0] rsp_determinant;
   logic rsp_singular;
   logic quiet_tail;
   int   idle_cycles;

   inverse_scoreboard_type board;

   matrix_inverse_3x3 DUT (
      .clock, .reset, .req_valid, .req_ready,
      .req_a00(req_a[0]), .req_a01(req_a[1]), .req_a02(req_a[2]),
      .req_a10(req_a[3]), .req_a11(req_a[4]), .req_a12(req_a[5]),
      .req_a20(req_a[6]), .req_a21(req_a[7]), .req_a22(req_a[8]),
      .rsp_valid, .rsp_ready,
      .rsp_b00(rsp_b[0]), .rsp_b01(rsp_b[1]), .rsp_b02(rsp_b[2]),
      .rsp_b10(rsp_b[3]), .rsp_b11(rsp_b[4]), .rsp_b12(rsp_b[5]),
      .rsp_b20(rsp_b[6]), .rsp_b21(rsp_b[7]), .rsp_b22(rsp_b[8]),
      .rsp_determinant, .rsp_singular
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;
   end

   // Acceptance of input words and checking of result words.
   always @(posedge clock) begin
      inverse_word_type got;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && req_ready) board.note_matrix(req_a);
         if (rsp_valid && rsp_ready) begin
            foreach (got.b[k]) got.b[k] = rsp_b[k];
            got.det = rsp_determinant;
            got.singular = rsp_singular;
            board.check_word(got);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 2000) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Receiver stalls in random bursts.
   initial begin
      rsp_ready = 0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_ready = 0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
         rsp_ready = 1;
      end
   end

   task automatic send_matrix(entry_type m [N_ENTRIES]);
      req_a = m;
      req_valid = 1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
   endtask

   function automatic entry_type random_entry();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         1: return entry_type'($signed($urandom_range(0, 16)) - 8);
         2: return entry_type'($signed($urandom_range(0, 8192)) - 4096);
         default: return entry_type'($urandom);
      endcase
   endfunction

   initial begin
      entry_type m [N_ENTRIES];
      int        r;
      req_valid = 0;
      quiet_tail = 0;
      foreach (req_a[k]) req_a[k] = '0;
      board = new();
      @(negedge reset);
      @(negedge clock);
      // Identity, zero, extremes, singular rows, scaled identities.
      m = '{16'sh1000, 0, 0, 0, 16'sh1000, 0, 0, 0, 16'sh1000};
      send_matrix(m);
      m = '{default: 0};
      send_matrix(m);
      m = '{default: 16'sh7FFF};
      send_matrix(m);
      m = '{default: 16'sh8000};
      send_matrix(m);
      m = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000};
      send_matrix(m);
      m = '{16'sh7FFF, 0, 0, 0, 16'sh7FFF, 0, 0, 0, 16'sh7FFF};
      send_matrix(m);
      m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
      send_matrix(m);
      m = '{-1, 16'sh7FFF, 0, 0, 1, 0, 0, 0, 1};
      send_matrix(m);
      m = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
            1, -1, 1};
      send_matrix(m);
      m = '{1, 2, 3, 2, 4, 6, 7, 8, 9};
      send_matrix(m);
      m = '{0, 16'sh1000, 0, 16'sh1000, 0, 0, 0, 0, -16'sh1000};
      send_matrix(m);
      m = '{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
            16'sh1234, 16'shFEDC, 16'sh0F0F};
      send_matrix(m);
      for (int i = 0; i < 1450; i++) begin
         foreach (m[k]) m[k] = random_entry();
         r = $urandom_range(0, 9);
         if (r == 0) begin
            m[6:8] = m[0:2];
         end else if (r == 1) begin
            foreach (m[k]) if (k % 3 == 2) m[k] = 0;
         end else if (r == 2) begin
            foreach (m[k]) if (k % 4 != 0) m[k] = 0;
         end
         if (i == 700) begin
            req_valid = 0;
            while (board.pending.size() != 0) @(posedge clock);
            @(negedge clock);
         end
         if (i == 1300) quiet_tail = 1;
         send_matrix(m);
      end
      req_valid = 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
